// ===== rtl/cordic_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the arctangent table for the cordic atan2/magnitude block
// no dependencies

package cordic_pkg;

	localparam int ITERATIONS = 23;
	localparam int FRAC_BITS  = 24;

	localparam int DATA_W    = 32;
	localparam int ANG_W     = 26;
	localparam int TAB_LEN   = 30;
	localparam int TAB_IDX_W = $clog2(TAB_LEN);
	localparam int CNT_W     = $clog2(ITERATIONS);
	localparam int GAIN_W    = FRAC_BITS;
	localparam int PROD_W    = DATA_W + GAIN_W + 1;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 64;

	// 0.6072529 in fixed point, truncated
	localparam logic [63:0] GAIN_FULL = (64'd6072529 << FRAC_BITS) / 64'd10000000;
	localparam logic [GAIN_W-1:0] GAIN = GAIN_FULL[GAIN_W-1:0];

	localparam logic [DATA_W-1:0] ANG_HALF_FULL = 32'd1 << (FRAC_BITS - 1);
	localparam logic [DATA_W-1:0] ANG_TURN_FULL = 32'd1 << FRAC_BITS;
	localparam logic [ANG_W-1:0]  ANG_HALF      = ANG_HALF_FULL[ANG_W-1:0];
	localparam logic [ANG_W-1:0]  ANG_TURN      = ANG_TURN_FULL[ANG_W-1:0];

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERATIONS - 1);

	// atan(2^-i) / (2 pi) * 2^32, truncated
	localparam logic [DATA_W-1:0] ATAN_TURNS32 [TAB_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_MUL
	} state_t;

	// table angle for one step, scaled to the angle format
	function automatic logic [ANG_W-1:0] atan_step(input logic [TAB_IDX_W-1:0] idx);
		logic [DATA_W-1:0] full;
		full = ATAN_TURNS32[idx] >> (DATA_W - FRAC_BITS);
		return full[ANG_W-1:0];
	endfunction

endpackage

// ===== rtl/cordic_atan2_magnitude.sv =====
`timescale 1ns / 1ps
// an accepted item runs 23 vectoring steps, then one gain multiply, before output tvalid
// items are processed one at a time, paced by the single
// shared add/shift unit that runs one vectoring step per cycle
// a new item is taken in the gain cycle if the output register is free
// reset (arst_n low, asynchronous) clears the sequencer and output valid; data registers hold
// depends on cordic_pkg

module cordic_atan2_magnitude (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] y_coord
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [25:0] angle_turns, [57:26] magnitude, rest zero
);

	cordic_pkg::state_t state_q, state_d;

	logic                                 in_acc;
	logic                                 out_free;
	logic                                 load_out;
	logic [cordic_pkg::CNT_W-1:0]         cnt_q;
	logic signed [cordic_pkg::DATA_W-1:0] x_q, y_q;
	logic [cordic_pkg::ANG_W-1:0]         ang_q;
	logic [cordic_pkg::ANG_W-1:0]         angle_q;
	logic [cordic_pkg::DATA_W-1:0]        mag_q;
	logic                                 m_valid_q;

	logic signed [cordic_pkg::DATA_W-1:0] x_in, y_in, x0, y0;
	logic [cordic_pkg::ANG_W-1:0]         ang0;
	logic signed [cordic_pkg::DATA_W-1:0] x_sh, y_sh, x_nx, y_nx;
	logic [cordic_pkg::ANG_W-1:0]         step, ang_nx;
	logic                                 ypos;
	logic signed [cordic_pkg::PROD_W-1:0] prod;

	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// range reduction of the incoming point
	assign x_in = $signed(s_axis_tdata[31:0]);
	assign y_in = $signed(s_axis_tdata[63:32]);

	always_comb begin
		if (x_in[cordic_pkg::DATA_W-1]) begin
			x0   = -x_in;
			y0   = -y_in;
			ang0 = cordic_pkg::ANG_HALF;
		end else begin
			x0   = x_in;
			y0   = y_in;
			ang0 = y_in[cordic_pkg::DATA_W-1] ? cordic_pkg::ANG_TURN : '0;
		end
	end

	// shared vectoring step
	assign ypos = !y_q[cordic_pkg::DATA_W-1] && (y_q != '0);
	assign x_sh = x_q >>> cnt_q;
	assign y_sh = y_q >>> cnt_q;
	assign step = cordic_pkg::atan_step(cordic_pkg::TAB_IDX_W'(cnt_q));

	always_comb begin
		if (ypos) begin
			x_nx   = x_q + y_sh;
			y_nx   = y_q - x_sh;
			ang_nx = ang_q + step;
		end else begin
			x_nx   = x_q - y_sh;
			y_nx   = y_q + x_sh;
			ang_nx = ang_q - step;
		end
	end

	// gain correction
	assign prod = x_q * $signed({1'b0, cordic_pkg::GAIN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cordic_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			cordic_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = cordic_pkg::ST_ITER;
				end
			end
			cordic_pkg::ST_ITER: begin
				if (cnt_q == cordic_pkg::CNT_LAST) begin
					state_d = cordic_pkg::ST_MUL;
				end
			end
			cordic_pkg::ST_MUL: begin
				if (out_free) begin
					load_out      = 1'b1;
					s_axis_tready = 1'b1;
					state_d       = s_axis_tvalid ? cordic_pkg::ST_ITER : cordic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cordic_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= '0;
		end else if (state_q == cordic_pkg::ST_ITER) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= x0;
			y_q   <= y0;
			ang_q <= ang0;
		end else if (state_q == cordic_pkg::ST_ITER) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			ang_q <= ang_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			angle_q <= ang_q;
			mag_q   <= prod[cordic_pkg::FRAC_BITS+cordic_pkg::DATA_W-1:cordic_pkg::FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(cordic_pkg::OUT_TDATA_W - cordic_pkg::DATA_W - cordic_pkg::ANG_W){1'b0}},
		mag_q, angle_q};

	// no item taken while the shared unit iterates
	a_no_ready_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cordic_pkg::ST_ITER) |-> !s_axis_tready)
		else $error("input ready during iteration");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == cordic_pkg::ST_ITER) && (cnt_q == '0))
		else $error("accepted item did not start iterating");

	a_iter_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == cordic_pkg::ST_ITER) && (cnt_q == cordic_pkg::CNT_LAST))
		|=> (state_q == cordic_pkg::ST_MUL))
		else $error("last step not followed by gain cycle");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == cordic_pkg::ST_MUL))
		else $error("output valid without gain cycle");

	// a result is only loaded into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!m_valid_q || m_axis_tready))
		else $error("output overwritten while stalled");

endmodule
